/* rtl/cv3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared types and constants of the streaming 3x3 convolution core.
// ----------------------------------------------------------------------------
package cv3_pkg;

   localparam int COEFF_BITS  = 4;
   localparam int TAPS        = 9;
   localparam int KERNEL_BITS = COEFF_BITS * TAPS;
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 13;
   localparam int ROW_BITS    = HEIGHT_BITS + 1;
   localparam int VALUE_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = 2'd2;

   // per-cell control: shift a new pixel in, capture the product, tap inside image
   typedef struct packed {
      logic shift;
      logic capture;
      logic tap_on;
   } cell_ctl_type;

endpackage : cv3_pkg
`default_nettype wire

/* rtl/cv3_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_cell
// One window tap: holds a pixel, hands it to its left neighbor on each shift
// and registers its masked product with one coefficient.
// ----------------------------------------------------------------------------
module cv3_cell
   import cv3_pkg::*;
#(
   parameter int PIXEL_BITS = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  cell_ctl_type                  ctl,
   input  wire  [PIXEL_BITS-1:0]               pixel_in,
   input  wire  signed [COEFF_BITS-1:0]        coeff,
   output logic [PIXEL_BITS-1:0]               pixel_out,
   output logic signed [PIXEL_BITS+COEFF_BITS:0] product
);

   logic [PIXEL_BITS-1:0]                 pixel_ff;
   logic signed [PIXEL_BITS+COEFF_BITS:0] product_ff;
   logic signed [PIXEL_BITS+COEFF_BITS:0] product_in;

   always_comb begin
      if (ctl.tap_on) begin
         product_in = $signed({1'b0, pixel_ff}) * coeff;
      end else begin
         product_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff <= '0;
      end else if (ctl.shift) begin
         pixel_ff <= pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         product_ff <= product_in;
      end
   end

   assign pixel_out = pixel_ff;
   assign product   = product_ff;

endmodule : cv3_cell
`default_nettype wire

/* rtl/conv3x3_zero_padded_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_core
// Streaming 3x3 convolution with zero padding over raster-order pixels.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle in both directions, no gaps while the
//   receiver takes each result; a held result stalls the whole pipeline.
// Path: a result passes the position stage, window cells, product registers and output.
// The line buffer is one dual-row memory with a registered read, bypassed when
//   the item ahead wrote the same column. Reset clears counters, window and
//   registers; the line buffer is not cleared (unwritten entries are masked).
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_core
   import cv3_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_mode,
   input  wire  [PIXEL_BITS-1:0]        req_pixel,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_value,
   output logic                         rsp_last_of_frame,
   input  wire                          csr_wr_en,
   input  wire  [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [KERNEL_BITS-1:0]       csr_wdata
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int PROD_W = PIXEL_BITS + COEFF_BITS + 1;
   localparam int SUM_W  = PROD_W + 4;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

   // configuration registers
   logic [KERNEL_BITS-1:0] kernel_ff;
   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= '0;
         width_ff  <= WIDTH_BITS'(256);
         height_ff <= HEIGHT_BITS'(256);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KERNEL: kernel_ff <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata[WIDTH_BITS-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size: zero counts as one, width saturates to the buffer
   logic [CW:0]            eff_w;
   logic [HEIGHT_BITS-1:0] eff_h;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = (CW+1)'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         eff_w = (CW+1)'(MAX_WIDTH);
      end else begin
         eff_w = (CW+1)'(width_ff);
      end
      eff_h = (height_ff == '0) ? HEIGHT_BITS'(1) : height_ff;
   end

   // the whole pipeline moves together; it only waits on a held result
   logic advance;
   logic accept;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // position counters
   logic [CW-1:0]       in_col_ff, out_col_ff;
   logic [ROW_BITS-1:0] in_row_ff, out_row_ff;
   logic [CW-1:0]       in_col_in, out_col_in;
   logic [ROW_BITS-1:0] in_row_in, out_row_in;

   logic [CW-1:0]         pos_x;
   logic [PIXEL_BITS-1:0] pos_px;
   logic                  pos_emit;
   logic                  pos_last;
   logic [TAPS-1:0]       pos_mask;

   always_comb begin
      logic [CW-1:0]       ic;
      logic [ROW_BITS-1:0] ir;
      logic [CW:0]         ic_next;
      logic [CW-1:0]       oc;
      logic [ROW_BITS-1:0] orow;
      logic [CW:0]         oc_next;
      logic [ROW_BITS-1:0] or_next;
      logic [2:0]          row_ok;
      logic [2:0]          col_ok;

      // wrap a column left beyond a narrowed width
      if ({1'b0, in_col_ff} >= eff_w) begin
         ic = '0;
         ir = in_row_ff + ROW_BITS'(1);
      end else begin
         ic = in_col_ff;
         ir = in_row_ff;
      end

      // flush items and rows below the image enter as zero
      if (req_mode || ir >= {1'b0, eff_h}) begin
         pos_px = '0;
      end else begin
         pos_px = req_pixel;
      end

      pos_emit = (ir >= ROW_BITS'(2)) || (ir == ROW_BITS'(1) && ic != '0);
      pos_x    = ic;

      ic_next = {1'b0, ic} + (CW+1)'(1);
      if (ic_next >= eff_w) begin
         in_col_in = '0;
         in_row_in = ir + ROW_BITS'(1);
      end else begin
         in_col_in = ic_next[CW-1:0];
         in_row_in = ir;
      end

      if ({1'b0, out_col_ff} >= eff_w) begin
         oc   = '0;
         orow = out_row_ff + ROW_BITS'(1);
      end else begin
         oc   = out_col_ff;
         orow = out_row_ff;
      end
      oc_next = {1'b0, oc} + (CW+1)'(1);
      or_next = orow + ROW_BITS'(1);

      // neighbor rows and columns that fall inside the image
      row_ok[0] = (orow != '0) && (orow <= {1'b0, eff_h});
      row_ok[1] = orow < {1'b0, eff_h};
      row_ok[2] = or_next < {1'b0, eff_h};
      col_ok[0] = oc != '0;
      col_ok[1] = {1'b0, oc} < eff_w;
      col_ok[2] = oc_next < eff_w;
      for (int r = 0; r < 3; r++) begin
         for (int s = 0; s < 3; s++) begin
            pos_mask[r*3+s] = row_ok[r] && col_ok[s];
         end
      end

      pos_last = (or_next >= {1'b0, eff_h}) && (oc_next >= eff_w);

      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (pos_emit) begin
         if (pos_last) begin
            // end of frame: every position returns to the origin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (oc_next >= eff_w) begin
            out_col_in = '0;
            out_row_in = or_next;
         end else begin
            out_col_in = oc_next[CW-1:0];
            out_row_in = orow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // stage 1: accepted item, line buffer read in flight
   logic                  s1_valid_ff;
   logic                  s1_emit_ff;
   logic                  s1_last_ff;
   logic [TAPS-1:0]       s1_mask_ff;
   logic [CW-1:0]         s1_x_ff;
   logic [PIXEL_BITS-1:0] s1_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_emit_ff <= pos_emit;
         s1_last_ff <= pos_emit && pos_last;
         s1_mask_ff <= pos_mask;
         s1_x_ff    <= pos_x;
         s1_px_ff   <= pos_px;
      end
   end

   // line buffer: {older row, newer row} per column
   logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
   logic [2*PIXEL_BITS-1:0] rd_ff;
   logic [2*PIXEL_BITS-1:0] fwd_data_ff;
   logic                    fwd_ff;
   logic [2*PIXEL_BITS-1:0] rd_eff;
   logic [2*PIXEL_BITS-1:0] wr_data;
   logic                    wr_en;

   assign rd_eff  = fwd_ff ? fwd_data_ff : rd_ff;
   assign wr_data = {rd_eff[PIXEL_BITS-1:0], s1_px_ff};
   assign wr_en   = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[s1_x_ff] <= wr_data;
      end
      if (advance) begin
         rd_ff       <= line_mem[pos_x];
         fwd_data_ff <= wr_data;
      end
   end

   // a read issued on the edge that writes the same column sees old data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (advance) begin
         fwd_ff <= s1_valid_ff && (s1_x_ff == pos_x);
      end
   end

   // stage 2: window cells hold the new neighborhood
   logic            s2_valid_ff;
   logic            s2_last_ff;
   logic [TAPS-1:0] s2_mask_ff;
   logic            s3_valid_ff;
   logic            s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_last_ff <= s1_last_ff;
         s2_mask_ff <= s1_mask_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // three chains of three cells; window row 0 is the oldest row
   logic [PIXEL_BITS-1:0]    row_in   [3];
   logic [PIXEL_BITS-1:0]    tap_pix  [TAPS];
   logic signed [PROD_W-1:0] tap_prod [TAPS];

   assign row_in[0] = rd_eff[2*PIXEL_BITS-1:PIXEL_BITS];
   assign row_in[1] = rd_eff[PIXEL_BITS-1:0];
   assign row_in[2] = s1_px_ff;

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar s = 0; s < 3; s++) begin : g_col
         cell_ctl_type ctl;
         logic [PIXEL_BITS-1:0] feed;

         assign ctl.shift   = wr_en;
         assign ctl.capture = advance;
         assign ctl.tap_on  = s2_mask_ff[r*3+s];

         if (s == 2) begin : g_head
            assign feed = row_in[r];
         end else begin : g_link
            assign feed = tap_pix[r*3+s+1];
         end

         cv3_cell #(
            .PIXEL_BITS(PIXEL_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .pixel_in  (feed),
            .coeff     ($signed(kernel_ff[COEFF_BITS*(r*3+s) +: COEFF_BITS])),
            .pixel_out (tap_pix[r*3+s]),
            .product   (tap_prod[r*3+s])
         );
      end
   end

   // stage 3: add the registered products, saturate, hold the result
   logic signed [SUM_W-1:0]      sum;
   logic signed [VALUE_BITS-1:0] sat_value;
   logic                         rsp_valid_ff;
   logic                         rsp_last_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff;

   always_comb begin
      sum = '0;
      for (int k = 0; k < TAPS; k++) begin
         sum = sum + SUM_W'(tap_prod[k]);
      end
      if (sum > SAT_HI) begin
         sat_value = VALUE_BITS'(SAT_HI);
      end else if (sum < SAT_LO) begin
         sat_value = VALUE_BITS'(SAT_LO);
      end else begin
         sat_value = sum[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= sat_value;
         rsp_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // the frame's final result sends every position back to the origin
   assert property (@(posedge clock) disable iff (reset)
      accept && pos_emit && pos_last |=>
         in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0)
      else $error("positions not cleared after end of frame");

   // only an item that makes a result can close the frame
   assert property (@(posedge clock) disable iff (reset)
      s1_last_ff |-> s1_emit_ff)
      else $error("end of frame flag on an item without a result");

   // a bypass needs a write from the item ahead on the previous edge
   assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_ff) |-> $past(s1_valid_ff && advance))
      else $error("line buffer bypass without a preceding write");

endmodule : conv3x3_zero_padded_core
`default_nettype wire

/* sim/tb_conv3x3_zero_padded_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_zero_padded_core
// Self-checking bench for the streaming 3x3 zero-padded convolution core.
// Frames of random pixels are streamed in under random sender and receiver
// idling. Each accepted transaction is run through a local filter predictor,
// and every result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_conv3x3_zero_padded_core;
   import cv3_pkg::*;

   localparam int MAX_W       = 1024;
   localparam int SETTLE      = 12;       // margin beyond the pipeline depth
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_LEN    = 300;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      bit       mode;
      bit [7:0] pixel;
   } pix_item_type;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      bit                           last;
   } filt_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_mode  = 1'b0;
   logic [7:0]                   req_pixel = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_value;
   logic                         rsp_last_of_frame;
   logic                         csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [KERNEL_BITS-1:0]       csr_wdata = '0;

   pix_item_type pixel_q[$];
   filt_out_type filt_q[$];

   int  send_idle = 0;
   int  recv_idle = 0;
   int  hold_kick = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  cycles    = 0;
   int  errors    = 0;

   // predictor state
   logic [KERNEL_BITS-1:0] kern_reg;
   logic [10:0]            width_reg;
   logic [12:0]            height_reg;
   bit   [7:0]             line_a[MAX_W];
   bit   [7:0]             line_b[MAX_W];
   bit   [7:0]             win[3][3];
   int                     in_col, in_row, out_col, out_row;

   conv3x3_zero_padded_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int eff_width(logic [10:0] w);
      if (w == 0) return 1;
      if (w > MAX_W) return MAX_W;
      return w;
   endfunction

   function automatic int eff_height(logic [12:0] h);
      return (h == 0) ? 1 : h;
   endfunction

   // Reset values of the filter state; line stores are don't-care (masked).
   function automatic void clear_filter();
      kern_reg   = '0;
      width_reg  = 11'd256;
      height_reg = 13'd256;
      foreach (line_a[i]) begin
         line_a[i] = '0;
         line_b[i] = '0;
      end
      foreach (win[r, s]) win[r][s] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // Advance the filter by one transaction; push the result it produces, if any.
   function automatic void filter_step(bit mode, bit [7:0] pix);
      int           w, h, x, sum, row, col;
      bit [7:0]     px;
      bit           emit, last;
      filt_out_type res;
      w  = eff_width(width_reg);
      h  = eff_height(height_reg);
      px = pix;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      // flush items and rows below the image enter as zero
      if (mode || in_row >= h) px = '0;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      x = (in_col >= MAX_W) ? MAX_W - 1 : in_col;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = line_b[x];
      win[1][2] = line_a[x];
      win[2][2] = px;
      line_b[x] = line_a[x];
      line_a[x] = px;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      sum = 0;
      for (int r = 0; r < 3; r++) begin
         row = out_row + r - 1;
         if (row < 0 || row >= h) continue;
         for (int s = 0; s < 3; s++) begin
            col = out_col + s - 1;
            if (col < 0 || col >= w) continue;
            sum += int'(win[r][s]) * int'($signed(kern_reg[4*(r*3+s) +: 4]));
         end
      end
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.value = sum[VALUE_BITS-1:0];
      res.last  = last;
      filt_q.push_back(res);
      if (last) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   // Driver: predict on each accepted transaction, hold a stalled one, refill.
   always @(posedge clock) begin
      pix_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) filter_step(req_mode, req_pixel);
         if (!req_valid || !req_stall) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               it = pixel_q.pop_front();
               req_valid <= 1'b1;
               req_mode  <= it.mode;
               req_pixel <= it.pixel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure; a long hold-off is counted here when kicked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= HOLD_LEN;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Monitor: compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      filt_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filt_q.size() == 0) begin
            $error("unexpected result value=%0d last=%0b", rsp_value, rsp_last_of_frame);
            errors++;
         end else begin
            want = filt_q.pop_front();
            if (rsp_value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_value);
               errors++;
            end
            if (rsp_last_of_frame !== want.last) begin
               $error("last_of_frame: expected %0b, got %0b", want.last, rsp_last_of_frame);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Wait until nothing is queued, in flight or expected, then let the pipe settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (pixel_q.size() > 0 || req_valid || filt_q.size() > 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [KERNEL_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // mirror the write into the predictor now that it has landed
      case (idx)
         CSR_KERNEL: kern_reg   = data;
         CSR_WIDTH:  width_reg  = data[10:0];
         CSR_HEIGHT: height_reg = data[12:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [KERNEL_BITS-1:0] kern, logic [10:0] w, logic [12:0] h);
      wait_idle();
      csr_write(CSR_KERNEL, kern);
      csr_write(CSR_WIDTH, {{(KERNEL_BITS-11){1'b0}}, w});
      csr_write(CSR_HEIGHT, {{(KERNEL_BITS-13){1'b0}}, h});
      // an unused index must leave every register alone
      if ($urandom_range(3) == 0) begin
         csr_write(CSR_UNUSED, KERNEL_BITS'({$urandom(), $urandom()}));
      end
   endtask

   // Queue one frame plus its drain; early flushes and late pixels mixed in.
   task automatic push_frame(int flush_pct, int late_pct);
      pix_item_type it;
      int           w, h;
      w = eff_width(width_reg);
      h = eff_height(height_reg);
      for (int i = 0; i < w * h; i++) begin
         it.mode  = ($urandom_range(99) < flush_pct);
         it.pixel = 8'($urandom_range(255));
         pixel_q.push_back(it);
      end
      for (int i = 0; i <= w; i++) begin
         it.mode  = ($urandom_range(99) >= late_pct);
         it.pixel = 8'($urandom_range(255));
         pixel_q.push_back(it);
      end
   endtask

   task automatic push_fixed(bit [7:0] pix, int cnt);
      pix_item_type it;
      it.mode  = 1'b0;
      it.pixel = pix;
      repeat (cnt) pixel_q.push_back(it);
   endtask

   initial begin
      int sent;
      int w, h;
      logic [KERNEL_BITS-1:0] kern;
      clear_filter();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme kernels (all +7, then all -8) on full-scale pixels, 3x3 frame.
      configure({TAPS{4'h7}}, 11'd3, 13'd3);
      push_fixed(8'hFF, 9);
      push_frame(0, 100);                   // drain with late pixels only
      configure({TAPS{4'h8}}, 11'd3, 13'd3);
      push_fixed(8'hFF, 9);
      push_frame(0, 0);
      // single-pixel frame, mixed kernel, early flush inside the image
      configure(36'h8_7F_01_7_8, 11'd1, 13'd1);
      push_frame(50, 50);
      push_frame(100, 0);
      // zero register values and a tall one-pixel-wide frame
      configure(KERNEL_BITS'({$urandom(), $urandom()}), 11'd0, 13'd0);
      push_frame(0, 50);
      configure(KERNEL_BITS'({$urandom(), $urandom()}), 11'd1, 13'd40);
      push_frame(5, 50);

      // Random frames: sender idles lightly and receiver heavily, then the
      // reverse, then neither.
      sent = 0;
      while (sent < 630) begin
         if (sent < 210) begin
            send_idle = 15;
            recv_idle = 80;
         end else if (sent < 420) begin
            send_idle = 80;
            recv_idle = 15;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         h = $urandom_range(1, 8);
         kern = KERNEL_BITS'({$urandom(), $urandom()});
         configure(kern, 11'(w), 13'(h));
         push_frame(3, 25);
         sent += w * h + w + 1;
         if ($urandom_range(2) == 0) begin
            push_frame(3, 25);
            sent += w * h + w + 1;
         end
      end

      // Back-pressure: hold the receiver off while a large frame streams in,
      // so the core fills up and stalls its input.
      send_idle = 0;
      recv_idle = 0;
      configure(KERNEL_BITS'({$urandom(), $urandom()}), 11'd16, 13'd8);
      push_frame(3, 25);
      @(posedge clock);
      hold_kick <= hold_kick + 1;
      // then pause the sender until every result has drained
      wait_idle();
      push_frame(3, 25);

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
